// File: rtl/core/dhkrt_pkg.sv
// ----------------------------------------------------------------------------
// dhkrt_pkg
// Shared types and constants of the double hashing key read table.
// ----------------------------------------------------------------------------
package dhkrt_pkg;

  localparam int unsigned SLOTS_DEF      = 4096;
  localparam int unsigned READ_DEPTH_DEF = 65536;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned BASE_W   = 16;
  localparam int unsigned RID_W    = 24;
  localparam int unsigned TSIZE_W  = 13;
  localparam int unsigned SMOD_W   = 12;
  localparam int unsigned MAXH_W   = 7;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned HIT_W    = 16;
  localparam int unsigned EMIT_LIM = 64;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;
  localparam logic [1:0] CMD_FIND   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_OVER      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // register indexes
  localparam logic [1:0] REG_TSIZE = 2'd0;
  localparam logic [1:0] REG_SMOD  = 2'd1;
  localparam logic [1:0] REG_MAXH  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic div_go;     // start the two mod units
    logic probe_rd;   // issue slot read at current probe index
    logic probe_adv;  // advance probe index
    logic ins_new;    // write a new key into slot
    logic ins_base;   // rewrite base of an existing slot
    logic add_wr;     // append read id, bump count
    logic get_init;   // start read walk
    logic get_rd;     // issue read store read
    logic emit;       // drive a result
    logic [2:0] emit_status;
    logic emit_last;
    logic emit_zero;  // slot and count forced to zero
    logic emit_read;  // read_out from read store data
  } dhkrt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic slot_valid;
    logic key_match;
    logic walk_end;   // probe count reached table size
    logic room;       // used slots below table size
    logic count_sat;
    logic count_zero;
    logic count_over;
    logic get_done;   // final read about to be emitted
  } dhkrt_sts_t;

endpackage

// File: rtl/core/dhkrt_mod.sv
// ----------------------------------------------------------------------------
// dhkrt_mod
// Bit-serial restoring remainder unit: 64-bit dividend by a 13-bit modulus.
// ----------------------------------------------------------------------------
module dhkrt_mod #(
  parameter int unsigned DW = 64,
  parameter int unsigned MW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [MW-1:0] modulus,
  output logic          done,
  output logic [MW-1:0] rem
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] sh_r;
  logic [MW:0]   acc_r;
  logic [MW-1:0] m_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [MW:0]   trial;

  // one dividend bit a cycle
  always_comb begin
    trial = {acc_r[MW-1:0], sh_r[DW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
      sh_r   <= dividend;
      m_r    <= modulus;
      acc_r  <= '0;
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      sh_r  <= {sh_r[DW-2:0], 1'b0};
      if (trial >= {1'b0, m_r}) acc_r <= trial - {1'b0, m_r};
      else acc_r <= trial;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign done = busy_r && cnt_r == '0;
  assign rem  = acc_r[MW-1:0];

endmodule

// File: rtl/core/dhkrt_datapath.sv
// ----------------------------------------------------------------------------
// dhkrt_datapath
// Slot memories, read store, probe walk arithmetic and result registers.
// ----------------------------------------------------------------------------
module dhkrt_datapath #(
  parameter int unsigned SLOTS      = dhkrt_pkg::SLOTS_DEF,
  parameter int unsigned READ_DEPTH = dhkrt_pkg::READ_DEPTH_DEF,
  parameter int unsigned COUNT_BITS = dhkrt_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dhkrt_pkg::dhkrt_cmd_t               cmd,
  output dhkrt_pkg::dhkrt_sts_t               sts,
  input  logic [dhkrt_pkg::TSIZE_W-1:0]       table_size,
  input  logic [dhkrt_pkg::SMOD_W-1:0]        step_modulus,
  input  logic [dhkrt_pkg::MAXH_W-1:0]        max_hits,
  input  logic [dhkrt_pkg::KEY_W-1:0]         in_key,
  input  logic [dhkrt_pkg::BASE_W-1:0]        in_base_offset,
  input  logic [dhkrt_pkg::RID_W-1:0]         in_read_id,
  output logic                                out_valid,
  output logic [2:0]                          out_status,
  output logic [dhkrt_pkg::SLOT_W-1:0]        out_slot,
  output logic [dhkrt_pkg::RID_W-1:0]         out_read_out,
  output logic [dhkrt_pkg::HIT_W-1:0]         out_hit_count,
  output logic                                out_last
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned MW = SW + 1;               // holds table size itself
  localparam int unsigned AW = $clog2(READ_DEPTH);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // slot memories
  logic                  valid_r [SLOTS];
  logic [63:0]           key_mem [SLOTS];
  logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
  logic [AW-1:0]         base_mem [SLOTS];
  logic [dhkrt_pkg::RID_W-1:0] rs_mem [READ_DEPTH];

  logic [63:0]           key_r;
  logic [AW-1:0]         base_in_r;
  logic [dhkrt_pkg::RID_W-1:0] rid_r;
  logic [MW-1:0]         m_r;
  logic [SW-1:0]         idx_r;
  logic [MW-1:0]         step_r;
  logic [MW-1:0]         n_r;
  logic [MW-1:0]         used_r;
  logic                  rd_valid_r;
  logic [63:0]           rd_key_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;
  logic [AW-1:0]         rd_base_r;
  logic [dhkrt_pkg::RID_W-1:0] rs_q_r;
  logic [6:0]            k_r;
  logic                  seeded_r;

  logic [MW-1:0]         m_eff;
  logic [dhkrt_pkg::SMOD_W-1:0] s_eff;
  logic                  d0_done, d1_done;
  logic [MW-1:0]         rem_m;
  logic [dhkrt_pkg::SMOD_W-1:0] rem_s;
  logic [MW:0]           adv_sum;
  logic [MW:0]           step_raw;
  logic [6:0]            lim;
  logic                  vrd;

  // effective table size, clamped to three and the slot count
  always_comb begin
    if (table_size < dhkrt_pkg::TSIZE_W'(3)) m_eff = MW'(3);
    else if ({{(MW > dhkrt_pkg::TSIZE_W ? MW - dhkrt_pkg::TSIZE_W : 0){1'b0}}, table_size}
             > (MW+dhkrt_pkg::TSIZE_W)'(SLOTS)) m_eff = MW'(SLOTS);
    else m_eff = MW'(table_size);
    s_eff = (step_modulus == '0) ? dhkrt_pkg::SMOD_W'(1) : step_modulus;
  end

  // key mod table size and key mod step modulus
  dhkrt_mod #(.DW(64), .MW(MW)) u_mod_m (
    .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .dividend(key_r),
    .modulus(m_r), .done(d0_done), .rem(rem_m));

  dhkrt_mod #(.DW(64), .MW(dhkrt_pkg::SMOD_W)) u_mod_s (
    .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .dividend(key_r),
    .modulus(s_eff), .done(d1_done), .rem(rem_s));

  // raw step is s - key mod s, at most 4095; it is reduced below m by repeated subtraction
  always_comb begin
    step_raw = (MW+1)'(s_eff) - (MW+1)'(rem_s);
    adv_sum  = (MW+1)'(idx_r) + (MW+1)'(step_r);
    if (adv_sum >= (MW+1)'(m_r)) adv_sum = adv_sum - (MW+1)'(m_r);
    lim = (max_hits < 7'(dhkrt_pkg::EMIT_LIM)) ? max_hits : 7'(dhkrt_pkg::EMIT_LIM);
  end

  // control registers of the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= MW'(1);
      seeded_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) valid_r[i] <= 1'b0;
    end else begin
      if (cmd.load) seeded_r <= 1'b0;
      if (cmd.ins_new) begin
        valid_r[idx_r] <= 1'b1;
        used_r         <= used_r + 1'b1;
      end
      // step reduced by repeated subtract once the divide is done
      if (d0_done && d1_done && !seeded_r) begin
        seeded_r <= 1'b1;
        idx_r    <= rem_m[SW-1:0];
        step_r   <= step_raw[MW-1:0];
      end else if (seeded_r && step_r >= m_r) begin
        step_r <= step_r - m_r;
      end else if (cmd.probe_adv) begin
        idx_r <= adv_sum[SW-1:0];
      end
    end
  end

  // request capture and walk counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= in_key;
      base_in_r <= AW'(in_base_offset);
      rid_r     <= in_read_id;
      m_r       <= m_eff;
      n_r       <= '0;
    end else if (cmd.probe_adv) begin
      n_r <= n_r + 1'b1;
    end
  end

  // slot memory ports
  always_ff @(posedge clk) begin
    if (cmd.probe_rd) begin
      rd_key_r  <= key_mem[idx_r];
      rd_cnt_r  <= cnt_mem[idx_r];
      rd_base_r <= base_mem[idx_r];
    end
    if (cmd.ins_new) begin
      key_mem[idx_r]  <= key_r;
      cnt_mem[idx_r]  <= '0;
      base_mem[idx_r] <= base_in_r;
    end else if (cmd.ins_base) begin
      base_mem[idx_r] <= base_in_r;
    end else if (cmd.add_wr) begin
      cnt_mem[idx_r] <= rd_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_valid_r <= 1'b0;
    else if (cmd.probe_rd) rd_valid_r <= valid_r[idx_r];
  end
  assign vrd = rd_valid_r;

  // read store port
  always_ff @(posedge clk) begin
    if (cmd.add_wr) rs_mem[rd_base_r + AW'(rd_cnt_r)] <= rid_r;
    if (cmd.get_rd) rs_q_r <= rs_mem[rd_base_r + AW'(k_r)];
  end

  always_ff @(posedge clk) begin
    if (cmd.get_init) k_r <= '0;
    else if (cmd.get_rd) k_r <= k_r + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit;
    if (cmd.emit) begin
      out_status    <= cmd.emit_status;
      out_last      <= cmd.emit_last;
      out_slot      <= cmd.emit_zero ? '0 : dhkrt_pkg::SLOT_W'(idx_r);
      out_read_out  <= cmd.emit_read ? rs_q_r : '0;
      if (cmd.emit_zero) out_hit_count <= '0;
      else if (cmd.ins_new) out_hit_count <= '0;
      else if (cmd.add_wr) out_hit_count <= dhkrt_pkg::HIT_W'(rd_cnt_r + 1'b1);
      else out_hit_count <= dhkrt_pkg::HIT_W'(rd_cnt_r);
    end
  end

  assign sts.div_done   = seeded_r && step_r < m_r;
  assign sts.slot_valid = vrd;
  assign sts.key_match  = rd_key_r == key_r;
  assign sts.walk_end   = n_r >= m_r;
  assign sts.room       = used_r < m_r;
  assign sts.count_sat  = rd_cnt_r == CNT_MAX;
  assign sts.count_zero = rd_cnt_r == '0;
  assign sts.count_over = rd_cnt_r > COUNT_BITS'(lim);
  assign sts.get_done   = COUNT_BITS'(k_r) == rd_cnt_r;

endmodule

// File: rtl/core/dhkrt_ctrl.sv
// ----------------------------------------------------------------------------
// dhkrt_ctrl
// Sequencer for hashing, probe walk, update and result emission.
// ----------------------------------------------------------------------------
module dhkrt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_command,
  output logic                  busy,
  output dhkrt_pkg::dhkrt_cmd_t cmd,
  input  dhkrt_pkg::dhkrt_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_READ, S_CHECK, S_GET_RD, S_GET_EM, S_GAP
  } state_t;

  state_t     st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  logic       go_r, go_nxt;

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    go_nxt = 1'b0;
    cmd    = '0;
    cmd.div_go = go_r;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          op_nxt   = in_command;
          go_nxt   = 1'b1;
          st_nxt   = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.div_done && !go_r) begin
          cmd.probe_rd = 1'b1;
          st_nxt       = S_READ;
        end
      end
      S_READ: st_nxt = S_CHECK;
      // decide on the slot just read
      S_CHECK: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        st_nxt        = S_GAP;
        if (sts.slot_valid && sts.key_match) begin
          case (op_r)
            dhkrt_pkg::CMD_INSERT: cmd.ins_base = 1'b1;
            dhkrt_pkg::CMD_ADD: cmd.add_wr = !sts.count_sat;
            dhkrt_pkg::CMD_GET: begin
              if (sts.count_over) cmd.emit_status = dhkrt_pkg::ST_OVER;
              else if (sts.count_zero) cmd.emit_status = dhkrt_pkg::ST_EMPTY;
              else begin
                cmd.emit     = 1'b0;
                cmd.emit_last = 1'b0;
                cmd.get_init = 1'b1;
                st_nxt       = S_GET_RD;
              end
            end
            default: ;
          endcase
        end else if (sts.slot_valid) begin
          cmd.emit      = 1'b0;
          cmd.emit_last = 1'b0;
          cmd.probe_adv = 1'b1;
          st_nxt        = S_HASH;
          if (sts.walk_end) begin
            cmd.probe_adv  = 1'b0;
            cmd.emit       = 1'b1;
            cmd.emit_last  = 1'b1;
            cmd.emit_zero  = 1'b1;
            cmd.emit_status = (op_r == dhkrt_pkg::CMD_INSERT) ?
                              dhkrt_pkg::ST_FULL : dhkrt_pkg::ST_NOT_FOUND;
            st_nxt = S_GAP;
          end
        end else begin
          cmd.emit_zero = 1'b1;
          if (op_r == dhkrt_pkg::CMD_INSERT && sts.room) begin
            cmd.ins_new   = 1'b1;
            cmd.emit_zero = 1'b0;
          end else if (op_r == dhkrt_pkg::CMD_INSERT) begin
            cmd.emit_status = dhkrt_pkg::ST_FULL;
          end else begin
            cmd.emit_status = dhkrt_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_GET_RD: begin
        cmd.get_rd = 1'b1;
        st_nxt     = S_GET_EM;
      end
      S_GET_EM: begin
        cmd.emit      = 1'b1;
        cmd.emit_read = 1'b1;
        if (sts.get_done) begin
          cmd.emit_last = 1'b1;
          st_nxt        = S_GAP;
        end else begin
          st_nxt = S_GET_RD;
        end
      end
      S_GAP: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // state and registered controls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      op_r <= dhkrt_pkg::CMD_INSERT;
      go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
      go_r <= go_nxt;
    end
  end

  assign busy = st_r != S_IDLE;

  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st_r != S_IDLE) else $error("emit while idle");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.ins_new, cmd.ins_base, cmd.add_wr}) <= 1)
    else $error("two slot writes at once");
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.emit_last |=> st_r == S_GAP) else $error("last not final");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> st_r == S_IDLE) else $error("load while busy");

endmodule

// File: rtl/core/double_hash_key_read_table_unit.sv
// ----------------------------------------------------------------------------
// double_hash_key_read_table_unit
// Open-addressing key table with double hashing and a shared read store.
// ----------------------------------------------------------------------------
// Hashing runs two bit-serial remainders together; each probe then passes
// S_HASH, S_READ and S_CHECK; get emits each read via S_GET_RD and S_GET_EM.
// Throughput: one request at a time; busy is high until the last result.
// Results are strobed for one cycle on out_valid and cannot be stalled.
// Reset clears slot valid bits at once and sets the used count to one.
module double_hash_key_read_table_unit #(
  parameter int unsigned SLOTS      = dhkrt_pkg::SLOTS_DEF,
  parameter int unsigned READ_DEPTH = dhkrt_pkg::READ_DEPTH_DEF,
  parameter int unsigned COUNT_BITS = dhkrt_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_key,
  input  logic [15:0] in_base_offset,
  input  logic [23:0] in_read_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [11:0] out_slot,
  output logic [23:0] out_read_out,
  output logic [15:0] out_hit_count,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] cfg_table_size_r;
  logic [11:0] cfg_step_modulus_r;
  logic [6:0]  cfg_max_hits_r;
  logic [1:0]  reg_idx;
  dhkrt_pkg::dhkrt_cmd_t cmd;
  dhkrt_pkg::dhkrt_sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_table_size_r   <= 13'd4093;
      cfg_step_modulus_r <= 12'd2039;
      cfg_max_hits_r     <= 7'd64;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        dhkrt_pkg::REG_TSIZE: cfg_table_size_r   <= pwdata[12:0];
        dhkrt_pkg::REG_SMOD:  cfg_step_modulus_r <= pwdata[11:0];
        dhkrt_pkg::REG_MAXH:  cfg_max_hits_r     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_idx)
        dhkrt_pkg::REG_TSIZE: prdata = {19'd0, cfg_table_size_r};
        dhkrt_pkg::REG_SMOD:  prdata = {20'd0, cfg_step_modulus_r};
        dhkrt_pkg::REG_MAXH:  prdata = {25'd0, cfg_max_hits_r};
        default: prdata = '0;
      endcase
    end
  end

  dhkrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_command(in_command),
    .busy(busy), .cmd(cmd), .sts(sts));

  dhkrt_datapath #(.SLOTS(SLOTS), .READ_DEPTH(READ_DEPTH), .COUNT_BITS(COUNT_BITS))
  u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .table_size(cfg_table_size_r), .step_modulus(cfg_step_modulus_r),
    .max_hits(cfg_max_hits_r), .in_key(in_key), .in_base_offset(in_base_offset),
    .in_read_id(in_read_id), .out_valid(out_valid), .out_status(out_status),
    .out_slot(out_slot), .out_read_out(out_read_out),
    .out_hit_count(out_hit_count), .out_last(out_last));

endmodule

// File: tb/dhkrt_checker.sv
// ----------------------------------------------------------------------------
// dhkrt_checker
// Watches the request, result and register ports of the key read table,
// predicts every result from its own copy of the table and compares them.
// ----------------------------------------------------------------------------
module dhkrt_checker
  import dhkrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_key,
  input  logic [15:0] in_base_offset,
  input  logic [23:0] in_read_id,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [11:0] out_slot,
  input  logic [23:0] out_read_out,
  input  logic [15:0] out_hit_count,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] slot;
    logic [23:0] read_out;
    logic [15:0] hit_count;
    logic        last;
  } table_result_t;

  typedef enum int {WALK_NONE, WALK_MATCH, WALK_FREE} walk_t;

  localparam int unsigned COUNT_SAT = (1 << COUNT_BITS_DEF) - 1;

  // shadow table and registers
  bit              valid_q  [SLOTS_DEF];
  logic [63:0]     key_q    [SLOTS_DEF];
  int unsigned     count_q  [SLOTS_DEF];
  int unsigned     base_q   [SLOTS_DEF];
  logic [23:0]     reads_q  [int unsigned];
  int unsigned     used_q;
  logic [12:0]     tsize_q;
  logic [11:0]     smod_q;
  logic [6:0]      maxh_q;

  table_result_t   expected_results[$];

  function automatic int unsigned table_span();
    int unsigned m;
    m = tsize_q;
    if (m < 3) m = 3;
    if (m > SLOTS_DEF) m = SLOTS_DEF;
    return m;
  endfunction

  // double hash walk: matching slot or first free one
  function automatic walk_t walk_table(logic [63:0] key, output int unsigned pos);
    int unsigned m;
    logic [63:0] s;
    int unsigned stride;
    int unsigned idx;
    m = table_span();
    s = (smod_q == 0) ? 64'd1 : 64'(smod_q);
    stride = int'((s - key % s) % m);
    idx = int'(key % m);
    pos = 0;
    for (int unsigned n = 0; n < m; n++) begin
      if (!valid_q[idx]) begin
        pos = idx;
        return WALK_FREE;
      end
      if (key_q[idx] == key) begin
        pos = idx;
        return WALK_MATCH;
      end
      idx = (idx + stride) % m;
    end
    return WALK_NONE;
  endfunction

  function automatic table_result_t mk(logic [2:0] st, int unsigned sl, logic [23:0] rd,
                                       int unsigned cnt, logic lst);
    table_result_t r;
    r.status = st;
    r.slot = sl[11:0];
    r.read_out = rd;
    r.hit_count = cnt[15:0];
    r.last = lst;
    return r;
  endfunction

  task automatic predict_request(logic [1:0] cmd, logic [63:0] key, logic [15:0] base,
                                 logic [23:0] rid);
    int unsigned pos;
    int unsigned c;
    int unsigned lim;
    int unsigned addr;
    walk_t w;
    w = walk_table(key, pos);
    if (cmd == CMD_INSERT) begin
      if (w == WALK_MATCH) begin
        base_q[pos] = base;
        expected_results.push_back(mk(ST_OK, pos, 0, count_q[pos], 1'b1));
      end else if (w == WALK_FREE && used_q < table_span()) begin
        valid_q[pos] = 1'b1;
        key_q[pos] = key;
        count_q[pos] = 0;
        base_q[pos] = base;
        used_q++;
        expected_results.push_back(mk(ST_OK, pos, 0, 0, 1'b1));
      end else begin
        expected_results.push_back(mk(ST_FULL, 0, 0, 0, 1'b1));
      end
    end else if (w != WALK_MATCH) begin
      expected_results.push_back(mk(ST_NOT_FOUND, 0, 0, 0, 1'b1));
    end else if (cmd == CMD_ADD) begin
      c = count_q[pos];
      if (c < COUNT_SAT) begin
        reads_q[(base_q[pos] + c) % READ_DEPTH_DEF] = rid;
        c++;
        count_q[pos] = c;
      end
      expected_results.push_back(mk(ST_OK, pos, 0, c, 1'b1));
    end else if (cmd == CMD_GET) begin
      c = count_q[pos];
      lim = (maxh_q < EMIT_LIM) ? maxh_q : EMIT_LIM;
      if (c > lim) begin
        expected_results.push_back(mk(ST_OVER, pos, 0, c, 1'b1));
      end else if (c == 0) begin
        expected_results.push_back(mk(ST_EMPTY, pos, 0, 0, 1'b1));
      end else begin
        for (int unsigned k = 0; k < c; k++) begin
          addr = (base_q[pos] + k) % READ_DEPTH_DEF;
          expected_results.push_back(mk(ST_OK, pos, reads_q.exists(addr) ? reads_q[addr] : 0,
                                        c, (k + 1 == c)));
        end
      end
    end else begin
      expected_results.push_back(mk(ST_OK, pos, 0, count_q[pos], 1'b1));
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  // reset, register writes, result compare, request prediction
  always @(posedge clk) begin
    table_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        valid_q[i] = 1'b0;
        key_q[i] = '0;
        count_q[i] = 0;
        base_q[i] = 0;
      end
      reads_q.delete();
      used_q = 1;
      tsize_q = 13'd4093;
      smod_q = 12'd2039;
      maxh_q = 7'd64;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TSIZE: tsize_q = pwdata[12:0];
          REG_SMOD:  smod_q  = pwdata[11:0];
          REG_MAXH:  maxh_q  = pwdata[6:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time,
                   {out_status, out_slot, out_read_out, out_hit_count, out_last});
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, out_status);
          check_field("slot", e.slot, out_slot);
          check_field("read_out", e.read_out, out_read_out);
          check_field("hit_count", e.hit_count, out_hit_count);
          check_field("last", e.last, out_last);
        end
      end
      if (start && !busy)
        predict_request(in_command, in_key, in_base_offset, in_read_id);
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/double_hash_key_read_table_unit_tb.sv
// ----------------------------------------------------------------------------
// double_hash_key_read_table_unit_tb
// Drives directed and random table requests through several register
// settings, with random request gaps; the checker compares every result.
// ----------------------------------------------------------------------------
module double_hash_key_read_table_unit_tb;
  import dhkrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_FIND;
  logic [63:0] in_key = '0;
  logic [15:0] in_base_offset = '0;
  logic [23:0] in_read_id = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [11:0] out_slot;
  logic [23:0] out_read_out;
  logic [15:0] out_hit_count;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  bit          gaps_on = 1'b1;
  int unsigned span = 4093;
  logic [63:0] key_pool[12];

  always #5 clk = ~clk;

  double_hash_key_read_table_unit uut (.*);

  dhkrt_checker chk (.*);

  // fixed region per key so a re-insert never points at unwritten reads
  function automatic logic [15:0] base_of(logic [63:0] k);
    return k[15:0] ^ k[31:16] ^ k[47:32] ^ k[63:48];
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [63:0] k, logic [23:0] rid);
    if (gaps_on && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_key <= k;
    in_base_offset <= (cmd == CMD_INSERT) ? base_of(k) : 16'($urandom);
    in_read_id <= rid;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // new setting, then a key pool with several keys sharing one home slot
  task automatic set_phase(int unsigned ts, int unsigned sm, int unsigned mh);
    int unsigned h;
    logic [63:0] k;
    reg_write(REG_TSIZE, ts);
    reg_write(REG_SMOD, sm);
    reg_write(REG_MAXH, mh);
    @(posedge clk);
    span = (ts < 3) ? 3 : (ts > SLOTS_DEF) ? SLOTS_DEF : ts;
    h = $urandom_range(span - 1);
    foreach (key_pool[i]) begin
      k = {$urandom, $urandom};
      key_pool[i] = (i < 6) ? k - (k % span) + h : k;
    end
  endtask

  task automatic random_requests(int n);
    int w;
    logic [1:0] cmd;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      gaps_on = !(i >= n / 3 && i < n / 3 + 15);
      w = $urandom_range(99);
      cmd = (w < 25) ? CMD_INSERT : (w < 65) ? CMD_ADD : (w < 85) ? CMD_GET : CMD_FIND;
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(11)] : {$urandom, $urandom};
      send_request(cmd, k, 24'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  // stimulus
  initial begin
    logic [63:0] kmax;
    kmax = '1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: missing key, empty list, id extremes, present key, collisions
    send_request(CMD_FIND, 64'd0, 24'd0);
    send_request(CMD_GET, 64'd0, 24'd0);
    send_request(CMD_ADD, 64'd0, 24'd1);
    send_request(CMD_INSERT, 64'd0, 24'd0);
    send_request(CMD_GET, 64'd0, 24'd0);
    send_request(CMD_ADD, 64'd0, 24'd0);
    send_request(CMD_ADD, 64'd0, 24'hFFFFFF);
    send_request(CMD_ADD, 64'd0, 24'($urandom));
    send_request(CMD_GET, 64'd0, 24'd0);
    send_request(CMD_FIND, 64'd0, 24'd0);
    send_request(CMD_INSERT, 64'd0, 24'd0);
    send_request(CMD_INSERT, kmax, 24'd0);
    send_request(CMD_ADD, kmax, 24'hFFFFFF);
    send_request(CMD_GET, kmax, 24'd0);
    send_request(CMD_INSERT, 64'd5, 24'd0);
    send_request(CMD_INSERT, 64'd5 + 4093, 24'd0);
    send_request(CMD_INSERT, 64'd5 + 2 * 4093, 24'd0);
    send_request(CMD_ADD, 64'd5 + 2 * 4093, 24'h123456);
    send_request(CMD_ADD, 64'd5 + 2 * 4093, 24'h654321);
    send_request(CMD_GET, 64'd5 + 2 * 4093, 24'd0);
    send_request(CMD_FIND, 64'd5 + 4093, 24'd0);
    send_request(CMD_FIND, 64'd5 + 3 * 4093, 24'd0);
    drain();

    // register settings, extremes among them
    set_phase(7, 5, 3);
    random_requests(40);
    drain();
    set_phase(3, 2, 0);
    random_requests(30);
    drain();
    set_phase(13, 11, 127);
    random_requests(45);
    drain();
    set_phase(8191, 0, 64);
    random_requests(45);
    drain();
    set_phase(2, 4095, 1);
    random_requests(25);
    drain();
    set_phase(4093, 2039, 64);
    random_requests(40);
    drain();
    set_phase(4096, 4095, 10);
    random_requests(30);
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule
